[hdl/tffs_pkg.sv]
// Shared constants and helpers for the triangle flip-free step unit.
// No dependencies.
package tffs_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int STEP_WIDTH_DEF  = 32;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

[hdl/triangle_flip_free_step_unit.sv]
// Top level of the triangle flip-free step unit.
// Depends on tffs_pkg, tffs_sqrt and tffs_div.
//
// Input stream (s_*): one triangle per transaction, twelve signed coordinates
// (three vertex positions, then three displacement directions). Output stream
// (m_*): the smallest positive step at which the triangle's signed area
// reaches zero, unsigned with STEP_WIDTH/2 fraction bits, rounded down and
// saturated; tuser flags an unbounded step (negative discriminant, zero
// leading coefficient or no positive root), step then all ones.
// Throughput: one transaction per cycle while the receiver is not stalling. The
// square root and the divider are pipelined, each resolving one result bit
// per stage.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls with a result held, s_tready is low and every
// stage holds. Reset clears all valid bits; no clearing pass is needed.
module triangle_flip_free_step_unit import tffs_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int STEP_WIDTH  = STEP_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// vertex0_u, vertex0_v, vertex1_u, vertex1_v, vertex2_u, vertex2_v,
	// move0_u, move0_v, move1_u, move1_v, move2_u, move2_v
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// step_size
	output logic [((STEP_WIDTH+7)/8)*8-1:0] m_tdata,
	// unbounded
	output logic [0:0] m_tuser
);

	localparam int W   = COORD_WIDTH;
	localparam int SW  = STEP_WIDTH;
	localparam int SF  = SW / 2;
	localparam int DW  = W + 1;
	localparam int PW  = 2 * DW;
	localparam int BW  = PW + 2;
	localparam int H   = (BW + 1) / 2;
	localparam int QW4 = 4 * H;
	localparam int DSW = QW4 + 3;
	localparam int DUW = 2 * BW;
	localparam int XW  = DUW + 2 * SF;
	localparam int RW  = XW / 2;
	localparam int MW  = BW + SF + 1;
	localparam int PLW = 4 + MW + BW;
	localparam int ODW = ((SW + 7) / 8) * 8;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic signed [W-1:0] crd [12];
	for (genvar k = 0; k < 12; k++) begin : g_crd
		assign crd[k] = s_tdata[k*W +: W];
	end

	// stage 1: edge differences pu,pv,qu,qv,eu,ev,fu,fv
	logic v_s1;
	logic signed [DW-1:0] df_s1 [8];

	// stage 2: cross-term products
	logic v_s2;
	logic signed [PW-1:0] pr_s2 [8];

	// stage 3: quadratic coefficients
	logic v_s3;
	logic signed [BW-1:0] a_s3, b_s3, c_s3;

	// stage 4: partial products of B*B and |A|*|C|
	logic v_s4;
	logic signed [BW-1:0] a_s4, b_s4, c_s4;
	logic [2*H-1:0] bll_s4, blh_s4, bhh_s4, all_s4, alh_s4, ahl_s4, ahh_s4;

	// stage 5: B*B and |A*C|
	logic v_s5;
	logic signed [BW-1:0] a_s5, b_s5, c_s5;
	logic [QW4-1:0] bb_s5, ac_s5;

	// stage 6: discriminant and normalized signs
	logic v_s6;
	logic [DUW-1:0] du_s6;
	logic [PLW-1:0] pl_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			df_s1[0] <= DW'(crd[2])  - DW'(crd[0]);
			df_s1[1] <= DW'(crd[3])  - DW'(crd[1]);
			df_s1[2] <= DW'(crd[4])  - DW'(crd[0]);
			df_s1[3] <= DW'(crd[5])  - DW'(crd[1]);
			df_s1[4] <= DW'(crd[8])  - DW'(crd[6]);
			df_s1[5] <= DW'(crd[9])  - DW'(crd[7]);
			df_s1[6] <= DW'(crd[10]) - DW'(crd[6]);
			df_s1[7] <= DW'(crd[11]) - DW'(crd[7]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2[0] <= df_s1[4] * df_s1[7];
			pr_s2[1] <= df_s1[5] * df_s1[6];
			pr_s2[2] <= df_s1[0] * df_s1[7];
			pr_s2[3] <= df_s1[1] * df_s1[6];
			pr_s2[4] <= df_s1[4] * df_s1[3];
			pr_s2[5] <= df_s1[5] * df_s1[2];
			pr_s2[6] <= df_s1[0] * df_s1[3];
			pr_s2[7] <= df_s1[1] * df_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= BW'(pr_s2[0]) - BW'(pr_s2[1]);
			b_s3 <= BW'(pr_s2[2]) - BW'(pr_s2[3]) + BW'(pr_s2[4]) - BW'(pr_s2[5]);
			c_s3 <= BW'(pr_s2[6]) - BW'(pr_s2[7]);
		end
	end

	logic [BW-1:0] ma, mb, mc;
	logic [H-1:0]  al, ah, bl, bh, cl, ch;
	assign ma = a_s3[BW-1] ? -a_s3 : a_s3;
	assign mb = b_s3[BW-1] ? -b_s3 : b_s3;
	assign mc = c_s3[BW-1] ? -c_s3 : c_s3;
	assign al = ma[H-1:0];
	assign bl = mb[H-1:0];
	assign cl = mc[H-1:0];
	assign ah = H'(ma >> H);
	assign bh = H'(mb >> H);
	assign ch = H'(mc >> H);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= a_s3;
			b_s4   <= b_s3;
			c_s4   <= c_s3;
			bll_s4 <= bl * bl;
			blh_s4 <= bl * bh;
			bhh_s4 <= bh * bh;
			all_s4 <= al * cl;
			alh_s4 <= al * ch;
			ahl_s4 <= ah * cl;
			ahh_s4 <= ah * ch;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s5  <= a_s4;
			b_s5  <= b_s4;
			c_s5  <= c_s4;
			bb_s5 <= (QW4'(bhh_s4) << (2*H)) + (QW4'(blh_s4) << (H+1)) + QW4'(bll_s4);
			ac_s5 <= (QW4'(ahh_s4) << (2*H)) + ((QW4'(alh_s4) + QW4'(ahl_s4)) << H)
				+ QW4'(all_s4);
		end
	end

	logic           aneg, bneg, cneg, azero, bnz, cnz, acneg;
	logic [DSW-1:0] ac4, dd;
	logic signed [MW-1:0] bsel;
	logic [BW-1:0]  aabs;
	logic           unb6, bn_neg6, c_pos6, c_neg6;

	assign aneg  = a_s5[BW-1];
	assign bneg  = b_s5[BW-1];
	assign cneg  = c_s5[BW-1];
	assign azero = (a_s5 == '0);
	assign bnz   = (b_s5 != '0);
	assign cnz   = (c_s5 != '0);
	assign acneg = aneg ^ cneg;
	assign ac4   = DSW'(ac_s5) << 2;
	assign dd    = acneg ? (DSW'(bb_s5) + ac4) : (DSW'(bb_s5) - ac4);
	assign bsel  = aneg ? MW'(b_s5) : -MW'(b_s5);
	assign aabs  = aneg ? -a_s5 : a_s5;
	assign unb6    = dd[DSW-1] || azero;
	assign bn_neg6 = aneg ? (!bneg && bnz) : bneg;
	assign c_pos6  = aneg ? cneg : (!cneg && cnz);
	assign c_neg6  = aneg ? (!cneg && cnz) : cneg;

	always_ff @(posedge clk) begin
		if (en) begin
			du_s6 <= dd[DUW-1:0];
			pl_s6 <= {unb6, bn_neg6, c_pos6, c_neg6, MW'(bsel <<< SF), aabs << 1};
		end
	end

	logic           sq_v, sq_remnz;
	logic [RW-1:0]  sq_root;
	logic [PLW-1:0] sq_pl;

	tffs_sqrt #(
		.XW  (XW),
		.PLW (PLW)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.x         ({du_s6, {(2*SF){1'b0}}}),
		.pl_in     (pl_s6),
		.out_valid (sq_v),
		.root      (sq_root),
		.rem_nz    (sq_remnz),
		.pl_out    (sq_pl)
	);

	logic          unb_n, bn_neg_n, c_pos_n, c_neg_n, case_small, case_large;
	logic [MW-1:0] mbk_n;
	logic [BW-1:0] den_n;
	logic [MW:0]   sroot, num_w;

	assign {unb_n, bn_neg_n, c_pos_n, c_neg_n, mbk_n, den_n} = sq_pl;
	assign case_small = bn_neg_n && c_pos_n;
	assign case_large = bn_neg_n || c_neg_n;
	assign sroot = (MW+1)'(sq_root) + (MW+1)'(case_small && sq_remnz);
	assign num_w = case_small ? ({mbk_n[MW-1], mbk_n} - sroot)
		: ({mbk_n[MW-1], mbk_n} + sroot);

	// stage 7: numerator select
	logic          v_s7, unb_s7;
	logic [MW-1:0] num_s7;
	logic [BW-1:0] den_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unb_s7 <= unb_n || !(case_small || case_large);
			num_s7 <= num_w[MW-1:0];
			den_s7 <= den_n;
		end
	end

	logic          dv_v, dv_ovf;
	logic [SW-1:0] dv_q;
	logic [0:0]    dv_unb;

	tffs_div #(
		.NW  (MW),
		.DNW (BW),
		.QW  (SW),
		.PLW (1)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       (num_s7),
		.den       (den_s7),
		.pl_in     (unb_s7),
		.out_valid (dv_v),
		.quo       (dv_q),
		.ovf       (dv_ovf),
		.pl_out    (dv_unb)
	);

	logic          out_v_q, unb_q;
	logic [SW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unb_q  <= dv_unb[0];
			step_q <= (dv_unb[0] || dv_ovf) ? '1 : dv_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = ODW'(step_q);
	assign m_tuser  = unb_q;

	a_unb_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (&m_tdata[SW-1:0]))
		else $error("unbounded result without saturated step");

	a_num_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v && en && !unb_n && (case_small || case_large) |-> !num_w[MW])
		else $error("negative root numerator");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s7) && $stable(sq_v))
		else $error("pipeline moved during stall");

endmodule

[hdl/tffs_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with side payload.
// Gives floor(sqrt(x)) and whether the remainder is nonzero. Standalone.
module tffs_sqrt #(
	parameter int XW  = 168,
	parameter int PLW = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [XW-1:0]  x,
	input  logic [PLW-1:0] pl_in,
	output logic           out_valid,
	output logic [XW/2-1:0] root,
	output logic           rem_nz,
	output logic [PLW-1:0] pl_out
);

	localparam int RW = XW / 2;

	logic           v_s    [RW+1];
	logic [RW+1:0]  rem_s  [RW+1];
	logic [RW-1:0]  root_s [RW+1];
	logic [XW-1:0]  x_s    [RW+1];
	logic [PLW-1:0] pl_s   [RW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			x_s[0]    <= x;
			pl_s[0]   <= pl_in;
		end
	end

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+1:0] r2;
		logic [RW+1:0] trial;
		logic          ge;

		assign r2    = {rem_s[i][RW-1:0], x_s[i][XW-1 -: 2]};
		assign trial = {root_s[i], 2'b01};
		assign ge    = (r2 >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= ge ? (r2 - trial) : r2;
				root_s[i+1] <= {root_s[i][RW-2:0], ge};
				x_s[i+1]    <= x_s[i] << 2;
				pl_s[i+1]   <= pl_s[i];
			end
		end
	end

	assign out_valid = v_s[RW];
	assign root      = root_s[RW];
	assign rem_nz    = (rem_s[RW] != '0);
	assign pl_out    = pl_s[RW];

endmodule

[hdl/tffs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on tffs_pkg.
module tffs_div import tffs_pkg::*; #(
	parameter int NW  = 85,
	parameter int DNW = 68,
	parameter int QW  = 32,
	parameter int PLW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [NW-1:0]  num,
	input  logic [DNW-1:0] den,
	input  logic [PLW-1:0] pl_in,
	output logic           out_valid,
	output logic [QW-1:0]  quo,
	output logic           ovf,
	output logic [PLW-1:0] pl_out
);

	localparam int DVW = max_int(NW, DNW + QW) + 1;

	logic           v_s   [QW+1];
	logic [NW-1:0]  rem_s [QW+1];
	logic [DNW-1:0] d_s   [QW+1];
	logic [QW-1:0]  q_s   [QW+1];
	logic           ovf_s [QW+1];
	logic [PLW-1:0] pl_s  [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			d_s[0]   <= den;
			q_s[0]   <= '0;
			ovf_s[0] <= (DVW'(num) >= (DVW'(den) << QW));
			pl_s[0]  <= pl_in;
		end
	end

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [DVW-1:0] dsh;
		logic [DVW-1:0] rx;
		logic [DVW-1:0] diff;
		logic           ge;

		assign dsh  = DVW'(d_s[i]) << (QW - 1 - i);
		assign rx   = DVW'(rem_s[i]);
		assign diff = rx - dsh;
		assign ge   = (rx >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[NW-1:0] : rem_s[i];
				d_s[i+1]   <= d_s[i];
				q_s[i+1]   <= {q_s[i][QW-2:0], ge};
				ovf_s[i+1] <= ovf_s[i];
				pl_s[i+1]  <= pl_s[i];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo       = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign pl_out    = pl_s[QW];

endmodule
